// File: src/nss_pkg.sv
// Package for the N-step SCAN disk scheduler: word types, codes, controller
// states, command/status structs and small helper functions.
// Depends on nothing; every other file of the block uses it.
package nss_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TRACK_COUNT     = 4096;
  localparam int TRACK_W         = 12;
  localparam int BATCH_W         = 5;
  localparam int FREE_W          = 5;
  localparam int TOTAL_W         = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 12;

  // Request types of an input word.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_SERVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_ADDED    = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_SERVED   = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // Sweep modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_INC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DIR   = 2'd2;

  localparam logic [BATCH_W-1:0] BATCH_SIZE_RST = 5'd4;
  localparam logic [TRACK_W-1:0] TRACK_MAX      = TRACK_W'(TRACK_COUNT - 1);

  typedef struct packed {
    logic               req_type;
    logic [TRACK_W-1:0] track;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TRACK_W-1:0] served_track;
    logic [TRACK_W-1:0] seek_distance;
    logic [1:0]         sweep_after;
    logic [FREE_W-1:0]  free_slots;
    logic [TOTAL_W-1:0] tracks_total;
    logic [TOTAL_W-1:0] served_total;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_PICK,
    ST_SHIFT,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic pick;
    logic shift;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic shift_done;
  } dp_stat_t;

  function automatic logic [TRACK_W-1:0] clamp_track(input logic [TRACK_W-1:0] t);
    return (32'(t) >= TRACK_COUNT) ? TRACK_MAX : t;
  endfunction

  function automatic logic [1:0] clamp_mode(input logic [1:0] m);
    return (m == MODE_INC || m == MODE_DEC) ? m : MODE_IDLE;
  endfunction

endpackage

// File: src/nss_datapath.sv
// Datapath of the N-step SCAN scheduler: request queue memory, head and
// sweep state, batch scan registers, compaction and the result register.
// Depends on nss_pkg; driven by commands from nss_controller.
module nss_datapath #(
  parameter int QUEUE_DEPTH = nss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nss_pkg::in_word_t                  in_data,
  input  logic                               cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  nss_pkg::dp_cmd_t                   cmd,
  output nss_pkg::dp_stat_t                  stat,
  output nss_pkg::out_word_t                 out_data
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = (CW > nss_pkg::BATCH_W) ? CW : nss_pkg::BATCH_W;
  localparam int TW = nss_pkg::TRACK_W;

  logic [TW-1:0] mem [QUEUE_DEPTH];
  logic          mem_we;
  logic [QW-1:0] mem_wa;
  logic [TW-1:0] mem_wd;
  logic [TW-1:0] rdata_r;

  // Latched input word.
  logic          req_r;
  logic [TW-1:0] trk_r;

  // Architectural state.
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 bl_r, bl_nxt;
  logic [TW-1:0]                 head_r, head_nxt;
  logic [1:0]                    mode_r, mode_nxt;
  logic [nss_pkg::TOTAL_W-1:0]   sum_r, sum_nxt;
  logic [nss_pkg::TOTAL_W-1:0]   svc_r, svc_nxt;
  logic [nss_pkg::BATCH_W-1:0]   bsize_r, bsize_nxt;

  // Scan and compaction pointers.
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          lag_vld_r, lag_vld_nxt;
  logic [QW-1:0] lag_idx_r, lag_idx_nxt;
  logic          issue;

  // Best candidates found by the scan.
  logic          hit_r, hit_nxt;
  logic [QW-1:0] hit_idx_r, hit_idx_nxt;
  logic          have_up_r, have_up_nxt;
  logic [QW-1:0] up_idx_r, up_idx_nxt;
  logic [TW-1:0] up_dist_r, up_dist_nxt;
  logic [TW-1:0] up_trk_r, up_trk_nxt;
  logic          have_dn_r, have_dn_nxt;
  logic [QW-1:0] dn_idx_r, dn_idx_nxt;
  logic [TW-1:0] dn_dist_r, dn_dist_nxt;
  logic [TW-1:0] dn_trk_r, dn_trk_nxt;

  // Per-item result fields.
  logic [1:0]    res_status_r, res_status_nxt;
  logic [TW-1:0] res_served_r, res_served_nxt;
  logic [TW-1:0] res_dist_r, res_dist_nxt;

  nss_pkg::out_word_t out_r;

  logic          full;
  logic [BW-1:0] bs_ext;
  logic [BW-1:0] bl_base;
  logic [CW-1:0] bl_new;
  logic [TW-1:0] d_up, d_dn;
  logic          any_up;
  logic          sel_up;
  logic [QW-1:0] sel_idx;
  logic [TW-1:0] sel_trk, sel_dist;
  logic [1:0]    sel_mode;

  assign full = (count_r == CW'(QUEUE_DEPTH));

  // A new batch takes min(batch size, pending); a zero batch size counts as one.
  assign bs_ext  = (bsize_r == '0) ? BW'(1) : BW'(bsize_r);
  assign bl_base = (bl_r == '0) ? bs_ext : BW'(bl_r);
  assign bl_new  = (bl_base < BW'(count_r)) ? CW'(bl_base) : count_r;

  assign d_up = rdata_r - head_r;
  assign d_dn = head_r - rdata_r;

  // Nearest entry overall, earliest index on a tie.
  assign any_up = have_up_r && (!have_dn_r || (up_dist_r < dn_dist_r) ||
                  ((up_dist_r == dn_dist_r) && (up_idx_r < dn_idx_r)));

  always_comb begin
    sel_up   = any_up;
    sel_mode = mode_r;
    unique case (mode_r)
      nss_pkg::MODE_INC: begin
        sel_up   = have_up_r;
        sel_mode = have_up_r ? nss_pkg::MODE_INC : nss_pkg::MODE_DEC;
      end
      nss_pkg::MODE_DEC: begin
        sel_up   = !have_dn_r;
        sel_mode = have_dn_r ? nss_pkg::MODE_DEC : nss_pkg::MODE_INC;
      end
      default: begin
        sel_up   = any_up;
        sel_mode = any_up ? nss_pkg::MODE_INC : nss_pkg::MODE_DEC;
      end
    endcase
    if (hit_r) begin
      sel_idx  = hit_idx_r;
      sel_trk  = head_r;
      sel_dist = '0;
      sel_mode = mode_r;
    end else if (sel_up) begin
      sel_idx  = up_idx_r;
      sel_trk  = up_trk_r;
      sel_dist = up_dist_r;
    end else begin
      sel_idx  = dn_idx_r;
      sel_trk  = dn_trk_r;
      sel_dist = dn_dist_r;
    end
  end

  // The scan reads batch entries in order; compaction reads entry j and
  // writes it to j-1 in the next cycle.
  always_comb begin
    issue = 1'b0;
    if (cmd.scan) begin
      issue = (ptr_r < bl_r);
    end else if (cmd.shift) begin
      issue = (ptr_r <= count_r);
    end
    ptr_nxt     = issue ? ptr_r + CW'(1) : ptr_r;
    lag_vld_nxt = issue;
    lag_idx_nxt = cmd.scan ? ptr_r[QW-1:0] : QW'(ptr_r - CW'(1));
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = lag_idx_r;
    mem_wd = rdata_r;
    if (cmd.exec && !req_r && !full) begin
      mem_we = 1'b1;
      mem_wa = count_r[QW-1:0];
      mem_wd = nss_pkg::clamp_track(trk_r);
    end else if (cmd.shift && lag_vld_r) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    bl_nxt         = bl_r;
    head_nxt       = head_r;
    mode_nxt       = mode_r;
    sum_nxt        = sum_r;
    svc_nxt        = svc_r;
    bsize_nxt      = bsize_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    have_up_nxt    = have_up_r;
    up_idx_nxt     = up_idx_r;
    up_dist_nxt    = up_dist_r;
    up_trk_nxt     = up_trk_r;
    have_dn_nxt    = have_dn_r;
    dn_idx_nxt     = dn_idx_r;
    dn_dist_nxt    = dn_dist_r;
    dn_trk_nxt     = dn_trk_r;
    res_status_nxt = res_status_r;
    res_served_nxt = res_served_r;
    res_dist_nxt   = res_dist_r;

    if (cfg_we) begin
      unique case (cfg_index)
        nss_pkg::CFG_BATCH_SIZE:  bsize_nxt = cfg_wdata[nss_pkg::BATCH_W-1:0];
        nss_pkg::CFG_START_TRACK: head_nxt  = nss_pkg::clamp_track(cfg_wdata[TW-1:0]);
        nss_pkg::CFG_START_DIR:   mode_nxt  = nss_pkg::clamp_mode(cfg_wdata[1:0]);
        default: ;
      endcase
    end

    if (cmd.exec) begin
      res_served_nxt = '0;
      res_dist_nxt   = '0;
      hit_nxt        = 1'b0;
      have_up_nxt    = 1'b0;
      have_dn_nxt    = 1'b0;
      if (!req_r) begin
        if (full) begin
          res_status_nxt = nss_pkg::STAT_REJECTED;
        end else begin
          count_nxt      = count_r + CW'(1);
          res_status_nxt = nss_pkg::STAT_ADDED;
        end
      end else if (count_r == '0) begin
        mode_nxt       = nss_pkg::MODE_IDLE;
        bl_nxt         = '0;
        res_status_nxt = nss_pkg::STAT_EMPTY;
      end else begin
        bl_nxt = bl_new;
      end
    end

    if (cmd.scan && lag_vld_r) begin
      if (rdata_r == head_r) begin
        if (!hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = lag_idx_r;
        end
      end else if (rdata_r > head_r) begin
        if (!have_up_r || d_up < up_dist_r) begin
          have_up_nxt = 1'b1;
          up_idx_nxt  = lag_idx_r;
          up_dist_nxt = d_up;
          up_trk_nxt  = rdata_r;
        end
      end else begin
        if (!have_dn_r || d_dn < dn_dist_r) begin
          have_dn_nxt = 1'b1;
          dn_idx_nxt  = lag_idx_r;
          dn_dist_nxt = d_dn;
          dn_trk_nxt  = rdata_r;
        end
      end
    end

    if (cmd.pick) begin
      count_nxt      = count_r - CW'(1);
      bl_nxt         = bl_r - CW'(1);
      head_nxt       = sel_trk;
      mode_nxt       = sel_mode;
      sum_nxt        = sum_r + nss_pkg::TOTAL_W'(sel_dist);
      svc_nxt        = svc_r + nss_pkg::TOTAL_W'(1);
      res_status_nxt = nss_pkg::STAT_SERVED;
      res_served_nxt = sel_trk;
      res_dist_nxt   = sel_dist;
    end
  end

  // Compaction starts with the entry after the served one.
  logic [CW-1:0] ptr_load;
  assign ptr_load = cmd.pick ? CW'(sel_idx) + CW'(1) : (cmd.exec ? '0 : ptr_nxt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[ptr_r[QW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      bl_r      <= '0;
      head_r    <= nss_pkg::clamp_track('0);
      mode_r    <= nss_pkg::MODE_IDLE;
      sum_r     <= '0;
      svc_r     <= '0;
      bsize_r   <= nss_pkg::BATCH_SIZE_RST;
      ptr_r     <= '0;
      lag_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      bl_r      <= bl_nxt;
      head_r    <= head_nxt;
      mode_r    <= mode_nxt;
      sum_r     <= sum_nxt;
      svc_r     <= svc_nxt;
      bsize_r   <= bsize_nxt;
      ptr_r     <= ptr_load;
      lag_vld_r <= lag_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data.req_type;
      trk_r <= in_data.track;
    end
    lag_idx_r    <= lag_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    have_up_r    <= have_up_nxt;
    up_idx_r     <= up_idx_nxt;
    up_dist_r    <= up_dist_nxt;
    up_trk_r     <= up_trk_nxt;
    have_dn_r    <= have_dn_nxt;
    dn_idx_r     <= dn_idx_nxt;
    dn_dist_r    <= dn_dist_nxt;
    dn_trk_r     <= dn_trk_nxt;
    res_status_r <= res_status_nxt;
    res_served_r <= res_served_nxt;
    res_dist_r   <= res_dist_nxt;
    if (cmd.load_out) begin
      out_r.status        <= res_status_r;
      out_r.served_track  <= res_served_r;
      out_r.seek_distance <= res_dist_r;
      out_r.sweep_after   <= mode_r;
      out_r.free_slots    <= nss_pkg::FREE_W'(CW'(QUEUE_DEPTH) - count_r);
      out_r.tracks_total  <= sum_r;
      out_r.served_total  <= svc_r;
    end
  end

  assign stat.need_scan  = req_r && (count_r != '0);
  assign stat.scan_done  = (ptr_r == bl_r);
  assign stat.shift_done = (ptr_r > count_r);
  assign out_data        = out_r;

endmodule

// File: src/nss_controller.sv
// Controller of the N-step SCAN scheduler: sequences accept, execute, scan,
// pick, compaction and result hand-off, and owns both handshakes.
// Depends on nss_pkg; drives nss_datapath through command signals.
module nss_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  nss_pkg::dp_stat_t  stat,
  output nss_pkg::dp_cmd_t   cmd
);

  nss_pkg::ctl_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nss_pkg::ST_IDLE:   if (in_valid) state_nxt = nss_pkg::ST_EXEC;
      nss_pkg::ST_EXEC:   state_nxt = stat.need_scan ? nss_pkg::ST_SCAN : nss_pkg::ST_FINISH;
      nss_pkg::ST_SCAN:   if (stat.scan_done) state_nxt = nss_pkg::ST_PICK;
      nss_pkg::ST_PICK:   state_nxt = nss_pkg::ST_SHIFT;
      nss_pkg::ST_SHIFT:  if (stat.shift_done) state_nxt = nss_pkg::ST_FINISH;
      nss_pkg::ST_FINISH: if (out_free) state_nxt = nss_pkg::ST_IDLE;
      default:            state_nxt = nss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept   = (state_r == nss_pkg::ST_IDLE) && in_valid;
    cmd.exec     = (state_r == nss_pkg::ST_EXEC);
    cmd.scan     = (state_r == nss_pkg::ST_SCAN);
    cmd.pick     = (state_r == nss_pkg::ST_PICK);
    cmd.shift    = (state_r == nss_pkg::ST_SHIFT);
    cmd.load_out = (state_r == nss_pkg::ST_FINISH) && out_free;
    in_stall     = (state_r != nss_pkg::ST_IDLE);
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/n_step_scan_disk_scheduler_top.sv
// N-step SCAN disk scheduler, top level.
//
// Input channel (in_valid / in_stall / in_data): each word either adds a
// track to the tail of the pending queue or asks for the next service.
// Output channel (out_valid / out_stall / out_data): exactly one result word
// per input word, in order. Configuration (cfg_we / cfg_index / cfg_wdata)
// sets the batch size; writing the start track or start direction presets
// the head position or sweep mode at once. Write only while the block is idle.
// One word is processed at a time. An add, or a service on an empty queue,
// passes from acceptance through the execute state to the result register.
// A service on a non-empty queue also scans the current batch (one queue read
// per entry through the single memory read port), picks an entry and then
// moves every entry behind the served one up one place, one per cycle, to
// keep queue order.
// The result register frees the input side: the next word is accepted while a
// result still waits. When the receiver stalls, the result holds and the block
// waits before loading the following result.
// Reset (synchronous, rst_n low) empties the queue, clears the totals, sets
// the head to track 0, idle mode and a batch size of 4.
module n_step_scan_disk_scheduler_top #(
  parameter int QUEUE_DEPTH = nss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  nss_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output nss_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  nss_pkg::dp_cmd_t  cmd;
  nss_pkg::dp_stat_t stat;

  nss_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  nss_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// File: dv/nss_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the N-step SCAN disk scheduler: follows the register writes,
// predicts one result word per accepted input word and compares it with the output.
// Depends on nss_pkg; instantiated beside the block by the testbench top.
module nss_result_checker #(
  parameter int QUEUE_DEPTH = nss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  nss_pkg::in_word_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  nss_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fail_count,
  output int                              words_due
);

  localparam int SHOW_MAX = 10;

  // Shadow of the scheduler: pending queue, batch, head and totals.
  logic [nss_pkg::TRACK_W-1:0] queued [QUEUE_DEPTH];
  int                          queued_len;
  int                          batch_left;
  logic [nss_pkg::TRACK_W-1:0] head;
  logic [1:0]                  sweep;
  logic [nss_pkg::BATCH_W-1:0] batch_reg;
  logic [nss_pkg::TOTAL_W-1:0] seek_sum;
  logic [nss_pkg::TOTAL_W-1:0] serve_sum;

  nss_pkg::out_word_t results_due_q [$];
  int                 mismatches;
  int                 words_seen;

  // Pick the entry to serve inside the current batch, updating the sweep mode.
  function automatic int choose_entry();
    int                          pick, best_any, best_up, best_dn;
    int                          dist_any, dist_up, dist_dn, d;
    logic                        have_up, have_dn, hit;
    logic [1:0]                  any_mode;
    logic [nss_pkg::TRACK_W-1:0] t;
    pick = 0;
    best_any = 0;
    best_up = 0;
    best_dn = 0;
    dist_any = nss_pkg::TRACK_COUNT;
    dist_up = nss_pkg::TRACK_COUNT;
    dist_dn = nss_pkg::TRACK_COUNT;
    have_up = 1'b0;
    have_dn = 1'b0;
    hit = 1'b0;
    any_mode = nss_pkg::MODE_IDLE;
    for (int i = 0; i < batch_left && i < QUEUE_DEPTH; i++) begin
      if (!hit) begin
        t = queued[i];
        if (t == head) begin
          // An exact hit wins at once and leaves the mode as it is.
          hit = 1'b1;
          pick = i;
        end else begin
          if (t > head) begin
            d = int'(t) - int'(head);
            if (d < dist_up) begin
              dist_up = d;
              best_up = i;
              have_up = 1'b1;
            end
          end else begin
            d = int'(head) - int'(t);
            if (d < dist_dn) begin
              dist_dn = d;
              best_dn = i;
              have_dn = 1'b1;
            end
          end
          if (d < dist_any) begin
            dist_any = d;
            best_any = i;
            any_mode = (t > head) ? nss_pkg::MODE_INC : nss_pkg::MODE_DEC;
          end
        end
      end
    end
    if (!hit) begin
      case (sweep)
        nss_pkg::MODE_INC: begin
          if (have_up) pick = best_up;
          else begin
            sweep = nss_pkg::MODE_DEC;
            pick = best_dn;
          end
        end
        nss_pkg::MODE_DEC: begin
          if (have_dn) pick = best_dn;
          else begin
            sweep = nss_pkg::MODE_INC;
            pick = best_up;
          end
        end
        default: begin
          sweep = any_mode;
          pick = best_any;
        end
      endcase
    end
    return pick;
  endfunction

  function automatic nss_pkg::out_word_t predict_schedule(input nss_pkg::in_word_t w);
    nss_pkg::out_word_t          r;
    int                          pick, bs, d;
    logic [nss_pkg::TRACK_W-1:0] served;
    r = '0;
    served = '0;
    d = 0;
    if (w.req_type == nss_pkg::REQ_ADD) begin
      if (queued_len >= QUEUE_DEPTH) r.status = nss_pkg::STAT_REJECTED;
      else begin
        queued[queued_len] = w.track;
        queued_len++;
        r.status = nss_pkg::STAT_ADDED;
      end
    end else if (queued_len == 0) begin
      sweep = nss_pkg::MODE_IDLE;
      batch_left = 0;
      r.status = nss_pkg::STAT_EMPTY;
    end else begin
      if (batch_left == 0) begin
        // A batch size of zero behaves as one.
        bs = (batch_reg == '0) ? 1 : int'(batch_reg);
        batch_left = (bs < queued_len) ? bs : queued_len;
      end
      if (batch_left > queued_len) batch_left = queued_len;
      pick = choose_entry();
      if (pick >= queued_len) pick = 0;
      served = queued[pick];
      d = (served >= head) ? int'(served) - int'(head) : int'(head) - int'(served);
      for (int i = pick; i + 1 < queued_len; i++) queued[i] = queued[i + 1];
      queued_len--;
      batch_left--;
      head = served;
      seek_sum = seek_sum + nss_pkg::TOTAL_W'(d);
      serve_sum = serve_sum + 1;
      r.status = nss_pkg::STAT_SERVED;
    end
    r.served_track  = served;
    r.seek_distance = nss_pkg::TRACK_W'(d);
    r.sweep_after   = sweep;
    r.free_slots    = nss_pkg::FREE_W'(QUEUE_DEPTH - queued_len);
    r.tracks_total  = seek_sum;
    r.served_total  = serve_sum;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v, inout logic bad);
    if (exp_v !== got_v) begin
      if (mismatches < SHOW_MAX)
        $display("%0t: result word %0d, %s: expected %0d, got %0d",
                 $realtime, words_seen, fname, exp_v, got_v);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin : monitor
    nss_pkg::out_word_t exp_w;
    logic               bad;
    if (!rst_n) begin
      queued_len = 0;
      batch_left = 0;
      head       = '0;
      sweep      = nss_pkg::MODE_IDLE;
      batch_reg  = nss_pkg::BATCH_SIZE_RST;
      seek_sum   = '0;
      serve_sum  = '0;
      mismatches = 0;
      words_seen = 0;
      results_due_q.delete();
      words_due  = 0;
      fail_count = 0;
    end else begin
      // The result leaving now belongs to an older word, so check it first.
      if (out_valid && !out_stall) begin
        if (results_due_q.size() == 0) begin
          if (mismatches < SHOW_MAX)
            $display("%0t: result word %0d arrived with nothing expected",
                     $realtime, words_seen);
          mismatches++;
          fail_count++;
        end else begin
          exp_w = results_due_q.pop_front();
          bad = 1'b0;
          check_field("status", 32'(exp_w.status), 32'(out_data.status), bad);
          check_field("served_track", 32'(exp_w.served_track),
                      32'(out_data.served_track), bad);
          check_field("seek_distance", 32'(exp_w.seek_distance),
                      32'(out_data.seek_distance), bad);
          check_field("sweep_after", 32'(exp_w.sweep_after),
                      32'(out_data.sweep_after), bad);
          check_field("free_slots", 32'(exp_w.free_slots), 32'(out_data.free_slots), bad);
          check_field("tracks_total", exp_w.tracks_total, out_data.tracks_total, bad);
          check_field("served_total", exp_w.served_total, out_data.served_total, bad);
          if (bad) begin
            mismatches++;
            fail_count++;
          end
        end
        words_seen++;
      end
      if (in_valid && !in_stall) begin
        results_due_q.insert(results_due_q.size(), predict_schedule(in_data));
      end
      if (cfg_we) begin
        case (cfg_index)
          nss_pkg::CFG_BATCH_SIZE:  batch_reg = cfg_wdata[nss_pkg::BATCH_W-1:0];
          nss_pkg::CFG_START_TRACK: head = cfg_wdata[nss_pkg::TRACK_W-1:0];
          nss_pkg::CFG_START_DIR: begin
            // The unused mode code falls back to idle.
            if (cfg_wdata[1:0] == nss_pkg::MODE_INC || cfg_wdata[1:0] == nss_pkg::MODE_DEC)
              sweep = cfg_wdata[1:0];
            else
              sweep = nss_pkg::MODE_IDLE;
          end
          default: ;
        endcase
      end
      words_due = results_due_q.size();
    end
  end

endmodule

// File: dv/n_step_scan_disk_scheduler_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the N-step SCAN disk scheduler: clock, reset, register writes
// and add/serve words under several idling mixes. Depends on nss_pkg, the block
// and nss_result_checker, which does all prediction and comparison.
module n_step_scan_disk_scheduler_top_tb;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_SLACK  = 50;
  localparam int PHASE_WORDS  = 150;

  localparam logic [1:0]                    MODE_UNDEF = 2'd3;
  localparam logic [nss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  nss_pkg::in_word_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall;
  nss_pkg::out_word_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int words_due;
  int gap_pct;
  int stall_pct;
  int hold_requests;
  int adds_sent;
  int serves_sent;

  logic [nss_pkg::TRACK_W-1:0] recent_tracks [8];
  int                          recent_wr;

  n_step_scan_disk_scheduler_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nss_result_checker #(.QUEUE_DEPTH(nss_pkg::QUEUE_DEPTH_DEF)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timed out with %0d result words outstanding", words_due);
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold whenever the stimulus asks for one.
  initial begin : receiver
    int holds_done;
    int n;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        for (n = 0; n < LONG_HOLD; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic nss_pkg::in_word_t mk_word(input logic req,
                                                input logic [nss_pkg::TRACK_W-1:0] t);
    nss_pkg::in_word_t w;
    w.req_type = req;
    w.track = t;
    return w;
  endfunction

  // Tracks lean toward repeats and near neighbors so that exact hits and ties occur.
  function automatic logic [nss_pkg::TRACK_W-1:0] pick_track();
    case ($urandom_range(7))
      0: return recent_tracks[$urandom_range(7)];
      1: return $urandom_range(1) ? nss_pkg::TRACK_MAX : '0;
      2: return recent_tracks[$urandom_range(7)] +
                nss_pkg::TRACK_W'($urandom_range(6)) - nss_pkg::TRACK_W'(3);
      default: return nss_pkg::TRACK_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // The caller then either offers the next word or lowers valid.
  task automatic send_word(input nss_pkg::in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.req_type == nss_pkg::REQ_ADD) begin
      recent_tracks[recent_wr] = w.track;
      recent_wr = (recent_wr + 1) % 8;
      adds_sent++;
    end else begin
      serves_sent++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nss_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    int k;
    int add_pct;
    int gap_mix [4];
    int stall_mix [4];
    gap_mix       = '{0, 86, 0, 34};
    stall_mix     = '{0, 0, 86, 34};
    gap_pct       = 0;
    stall_pct     = 0;
    hold_requests = 0;
    adds_sent     = 0;
    serves_sent   = 0;
    recent_wr     = 0;
    foreach (recent_tracks[i]) recent_tracks[i] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: batch of four, head at track zero, idle.
    send_word(mk_word(nss_pkg::REQ_SERVE, nss_pkg::TRACK_MAX));    // empty queue
    send_word(mk_word(nss_pkg::REQ_ADD, '0));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_MAX));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(2048)));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(2048)));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(1)));
    // Exact hit, tie, reversal, then an empty queue.
    repeat (6) send_word(mk_word(nss_pkg::REQ_SERVE, '0));

    // Decreasing sweep from a preset head, with an exact hit first.
    write_reg(nss_pkg::CFG_START_DIR, nss_pkg::CFG_DATA_W'(nss_pkg::MODE_DEC));
    write_reg(nss_pkg::CFG_START_TRACK, nss_pkg::CFG_DATA_W'(100));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(300)));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(100)));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(40)));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(160)));
    repeat (4) send_word(mk_word(nss_pkg::REQ_SERVE, nss_pkg::TRACK_MAX));

    // A batch size of zero acts as one.
    write_reg(nss_pkg::CFG_BATCH_SIZE, '0);
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(5)));
    send_word(mk_word(nss_pkg::REQ_ADD, nss_pkg::TRACK_W'(3)));
    repeat (2) send_word(mk_word(nss_pkg::REQ_SERVE, '0));

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(nss_pkg::CFG_BATCH_SIZE, nss_pkg::CFG_DATA_W'(16));
          write_reg(nss_pkg::CFG_START_TRACK, nss_pkg::CFG_DATA_W'(nss_pkg::TRACK_MAX));
          write_reg(nss_pkg::CFG_START_DIR, nss_pkg::CFG_DATA_W'(nss_pkg::MODE_INC));
        end
        1: begin
          write_reg(nss_pkg::CFG_BATCH_SIZE, nss_pkg::CFG_DATA_W'(31));
          write_reg(nss_pkg::CFG_START_TRACK, '0);
          write_reg(nss_pkg::CFG_START_DIR, nss_pkg::CFG_DATA_W'(nss_pkg::MODE_DEC));
        end
        2: begin
          write_reg(nss_pkg::CFG_BATCH_SIZE, nss_pkg::CFG_DATA_W'(1));
          write_reg(nss_pkg::CFG_START_TRACK, nss_pkg::CFG_DATA_W'($urandom));
          write_reg(nss_pkg::CFG_START_DIR, nss_pkg::CFG_DATA_W'(MODE_UNDEF));
        end
        default: begin
          write_reg(nss_pkg::CFG_BATCH_SIZE, nss_pkg::CFG_DATA_W'($urandom_range(15, 2)));
          write_reg(nss_pkg::CFG_START_TRACK, nss_pkg::CFG_DATA_W'($urandom));
          write_reg(nss_pkg::CFG_START_DIR, nss_pkg::CFG_DATA_W'(nss_pkg::MODE_IDLE));
          write_reg(CFG_UNUSED, nss_pkg::CFG_DATA_W'($urandom));
        end
      endcase
      gap_pct   = gap_mix[ph];
      stall_pct = stall_mix[ph];

      if (ph == 0) begin
        // Long receiver hold while words keep coming: the queue overflows
        // and the block has to stall its input.
        hold_requests++;
        repeat (24) send_word(mk_word(nss_pkg::REQ_ADD, pick_track()));
        repeat (6) send_word(mk_word(nss_pkg::REQ_SERVE, nss_pkg::TRACK_W'($urandom)));
      end

      for (k = 0; k < PHASE_WORDS; k++) begin
        // Alternate fill-heavy and drain-heavy stretches.
        add_pct = ((k / 25) % 2 == 0) ? 70 : 35;
        if ($urandom_range(99) < add_pct)
          send_word(mk_word(nss_pkg::REQ_ADD, pick_track()));
        else
          send_word(mk_word(nss_pkg::REQ_SERVE, nss_pkg::TRACK_W'($urandom)));
        if (k == PHASE_WORDS / 2) wait_drained();
      end
    end

    wait_drained();
    $display("Run sent %0d add words and %0d service words under four idling mixes,",
             adds_sent, serves_sent);
    $display("batch sizes 0, 1, 4, 16 and 31, every start mode and both track extremes.");
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
